### sv/aesd_pkg.sv
// Package for the AES-128 decrypt pipeline: types, constant tables and GF(2^8) helpers.
// Used by the key expansion, the round stage and the top level.
package aesd_pkg;

    localparam int unsigned NUM_ROUNDS = 10;

    typedef logic [7:0]   t_byte;
    typedef logic [31:0]  t_word;
    typedef logic [127:0] t_block;

    localparam logic [0:0] REG_KEY_HIGH = 1'b0;
    localparam logic [0:0] REG_KEY_LOW  = 1'b1;

    localparam t_byte SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam t_byte INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    localparam t_byte RCON [10] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    function automatic t_byte xtime(input t_byte a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Multiply by 9, 11, 13 and 14 from doubled values.
    function automatic t_word inv_mix_col(input t_word c);
        t_byte a [4];
        t_byte x2 [4];
        t_byte x4 [4];
        t_byte x8 [4];
        t_byte m9 [4];
        t_byte mb [4];
        t_byte md [4];
        t_byte me [4];
        for (int i = 0; i < 4; i++) begin
            a[i]  = c[31-8*i -: 8];
            x2[i] = xtime(a[i]);
            x4[i] = xtime(x2[i]);
            x8[i] = xtime(x4[i]);
            m9[i] = x8[i] ^ a[i];
            mb[i] = x8[i] ^ x2[i] ^ a[i];
            md[i] = x8[i] ^ x4[i] ^ a[i];
            me[i] = x8[i] ^ x4[i] ^ x2[i];
        end
        return {me[0] ^ mb[1] ^ md[2] ^ m9[3],
                m9[0] ^ me[1] ^ mb[2] ^ md[3],
                md[0] ^ m9[1] ^ me[2] ^ mb[3],
                mb[0] ^ md[1] ^ m9[2] ^ me[3]};
    endfunction

    // Inverse shift rows and inverse substitution; byte i sits at [127-8*i -: 8].
    function automatic t_block inv_shift_sub(input t_block s);
        t_block t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127-8*(r+4*c) -: 8] = INV_SBOX[s[127-8*(r+4*((c-r+4)%4)) -: 8]];
            end
        end
        return t;
    endfunction

    function automatic t_block inv_mix(input t_block s);
        t_block t;
        for (int c = 0; c < 4; c++) begin
            t[127-32*c -: 32] = inv_mix_col(s[127-32*c -: 32]);
        end
        return t;
    endfunction

endpackage

### sv/aesd_if.sv
// Valid/ready channel carrying one 128-bit block as two 64-bit halves.
// Standalone; used by the top level ports.
interface aesd_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_high;
    logic [63:0] data_low;

    modport source (output valid, output data_high, output data_low, input ready);
    modport sink (input valid, input data_high, input data_low, output ready);
endinterface

### sv/aesd_key_expand.sv
// Forward AES-128 key expansion, one round key per cycle, into a round key register file.
// Depends on aesd_pkg.
module aesd_key_expand
    import aesd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [127:0] i_key,
    output logic [127:0] o_round_keys [NUM_ROUNDS+1],
    output logic         o_busy
);
    logic [127:0] r_keys [NUM_ROUNDS+1];
    logic [127:0] r_cur;
    logic [3:0]   r_cnt;
    logic         r_busy;
    logic [127:0] n_next;
    t_word        w3;
    t_word        tw;

    always_comb begin
        w3 = r_cur[31:0];
        tw = {SBOX[w3[23:16]], SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]}
             ^ {RCON[r_cnt], 24'h0};
        n_next[127:96] = r_cur[127:96] ^ tw;
        n_next[95:64]  = r_cur[95:64] ^ n_next[127:96];
        n_next[63:32]  = r_cur[63:32] ^ n_next[95:64];
        n_next[31:0]   = r_cur[31:0] ^ n_next[63:32];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 4'd1;
            if (r_cnt == 4'(NUM_ROUNDS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cur     <= i_key;
            r_keys[0] <= i_key;
        end else if (r_busy) begin
            r_cur                  <= n_next;
            r_keys[r_cnt + 4'd1]   <= n_next;
        end
    end

    assign o_round_keys = r_keys;
    assign o_busy       = r_busy;
endmodule

### sv/aesd_round.sv
// One registered inverse round of the pipeline: shift/sub, key add, optional mix.
// Depends on aesd_pkg.
module aesd_round
    import aesd_pkg::*;
#(
    parameter bit LAST = 1'b0
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_valid,
    input  logic [127:0] i_state,
    input  logic [127:0] i_key,
    output logic         o_valid,
    output logic [127:0] o_state
);
    logic [127:0] r_state;
    logic         r_valid;
    logic [127:0] n_state;
    logic [127:0] keyed;

    always_comb begin
        keyed   = inv_shift_sub(i_state) ^ i_key;
        n_state = LAST ? keyed : inv_mix(keyed);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_state <= n_state;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;
endmodule

### sv/aes128_block_decrypt_unit.sv
// Top level of the AES-128 block decryptor: key registers, key expansion and round pipeline.
// Depends on aesd_pkg, aesd_if, aesd_key_expand and aesd_round.

// The unit decrypts one 128-bit AES-128 block per request and accepts a new
// request every clock cycle unless a result waits untaken at the output. A
// request passes an input key-add register and then ten round registers, one
// for each inverse round, before its plaintext appears at the output.
// The whole pipeline advances together; when a result waits at the output
// and is not taken, every stage holds and input ready drops in that cycle.
// Writing either key register starts the forward key expansion, which
// produces one round key per cycle and finishes once every round key is
// written; requests must not be sent until then. Decryption requests sent
// before any key write give undefined results.
module aes128_block_decrypt_unit
    import aesd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    aesd_if.sink        s_in,
    aesd_if.source      m_out,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);
    logic [63:0]  r_key_high;
    logic [63:0]  r_key_low;
    logic         r_start;
    logic [127:0] round_keys [NUM_ROUNDS+1];
    logic         kx_busy;

    // Stage 0 holds the ciphertext after the initial key add.
    logic         st_valid [NUM_ROUNDS+1];
    logic [127:0] st_state [NUM_ROUNDS+1];
    logic         r_v0;
    logic [127:0] r_s0;
    logic         adv;

    // Pipeline moves when the last stage is empty or its result is taken.
    assign adv        = !st_valid[NUM_ROUNDS] || m_out.ready;
    assign s_in.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
            r_start    <= 1'b0;
        end else begin
            r_start <= i_cfg_we;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_KEY_HIGH: r_key_high <= i_cfg_data;
                    REG_KEY_LOW:  r_key_low  <= i_cfg_data;
                    default:      r_key_high <= r_key_high;
                endcase
            end
        end
    end

    aesd_key_expand u_kx (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (r_start),
        .i_key        ({r_key_high, r_key_low}),
        .o_round_keys (round_keys),
        .o_busy       (kx_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (adv) begin
            r_v0 <= s_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s0 <= {s_in.data_high, s_in.data_low} ^ round_keys[NUM_ROUNDS];
        end
    end

    assign st_valid[0] = r_v0;
    assign st_state[0] = r_s0;

    for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_round
        aesd_round #(
            .LAST (g == NUM_ROUNDS - 1)
        ) u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_valid (st_valid[g]),
            .i_state (st_state[g]),
            .i_key   (round_keys[NUM_ROUNDS-1-g]),
            .o_valid (st_valid[g+1]),
            .o_state (st_state[g+1])
        );
    end

    assign m_out.valid     = st_valid[NUM_ROUNDS];
    assign m_out.data_high = st_state[NUM_ROUNDS][127:64];
    assign m_out.data_low  = st_state[NUM_ROUNDS][63:0];

`ifndef SYNTHESIS
    // A stalled result keeps its value until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid && !m_out.ready |=> m_out.valid && $stable(m_out.data_high))
        else $error("result changed while stalled");
    // A key write always starts the expansion, through the registered start pulse and then the busy flag.
    a_kx_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> ##1 kx_busy)
        else $error("key expansion did not start");
    // Input is taken whenever no result waits at the output.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_out.valid |-> s_in.ready)
        else $error("input blocked with empty output");
`endif
endmodule
